/* rtl/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg
// Shared constants and a magnitude function for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int WORD_BITS = 32;
	localparam int PROD_BITS = 2 * WORD_BITS;
	localparam int SHIFT_BITS = $clog2(PROD_BITS + 1);
	localparam int CNT_BITS = $clog2(PROD_BITS);

	localparam logic [2:0] KIND_ADD = 3'd0;
	localparam logic [2:0] KIND_SUB = 3'd1;
	localparam logic [2:0] KIND_MUL = 3'd2;
	localparam logic [2:0] KIND_DIV = 3'd3;

	localparam logic [1:0] ORD_LESS  = 2'd0;
	localparam logic [1:0] ORD_EQUAL = 2'd1;
	localparam logic [1:0] ORD_MORE  = 2'd2;

	function automatic logic [WORD_BITS-1:0] mag_of(input logic [WORD_BITS-1:0] x);
		return x[WORD_BITS-1] ? (~x + 1'b1) : x;
	endfunction

endpackage

/* rtl/rational_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Add, subtract, multiply, divide or compare two fractions; result reduced.
// ----------------------------------------------------------------------------
// Input request: s_tuser carries the operation, s_tdata the four operand
// words. One result request per input leaves on m_tdata.
// One request is worked on at a time: s_tready is high only while the
// sequencer is idle. A request makes three products on the shared
// multiplier, then the cross-product sum, binary gcd steps on 64-bit
// operands, then restoring division (numerator and denominator by the
// gcd), before m_tvalid rises.
// Compare requests leave after the cross-product sum, without gcd or
// division; requests with a zero input denominator go from idle straight
// to the final state.
// The finished result is held in an output register; while the receiver
// stalls, a following request is still taken and worked on, then waits in
// the final state and no further request is taken.
// arst_n clears the sequencer and the output valid at once.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // a_num, a_den, b_num, b_den
	input  logic [2:0]   s_tuser,   // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata    // res_num, res_den, order, zero_den_error, overflow
);
	import rau_pkg::*;

	localparam int W = WORD_BITS;
	localparam int P = PROD_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_GCD  = 3'd3;
	localparam logic [2:0] ST_DIVN = 3'd4;
	localparam logic [2:0] ST_DIVD = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	localparam logic [P-1:0] LIM = {{(P-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

	logic [2:0] state_q;
	logic [2:0] kind_q;
	logic [W-1:0] an_q, ad_q, bn_q, bd_q;
	logic an_s_q, bn_s_q;
	logic [1:0] mi_q;
	logic [P-1:0] p0_q, p1_q, p2_q;
	logic s0_q, s1_q;
	logic [P-1:0] n_q, d_q, u_q, v_q, g_q, dv_q, rem_q, nq_q;
	logic [SHIFT_BITS-1:0] k_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic neg_q;
	logic [31:0] rn_q;
	logic [30:0] rd_q;
	logic [1:0] ord_q;
	logic zde_q, ov_q;

	logic [W-1:0] in_an, in_ad, in_bn, in_bd;
	logic in_an_s, in_bn_s;
	logic [W-1:0] mx, my;
	logic ms;
	logic [P-1:0] prod;
	logic is_cmp;
	logic s1_eff;
	logic [P-1:0] sum_m;
	logic sum_s;
	logic [P-1:0] nm_c, dm_c;
	logic nn_c, dn_c;
	logic [P:0] r2;
	logic ge;
	logic [P-1:0] r2_sub;
	logic [P-1:0] nm_sat, dm_sat, resn;
	logic ov_c;
	logic out_free;

	assign in_ad = mag_of(s_tdata[32 +: W]);
	assign in_bd = mag_of(s_tdata[96 +: W]);
	assign in_an = mag_of(s_tdata[0 +: W]);
	assign in_bn = mag_of(s_tdata[64 +: W]);
	assign in_an_s = s_tdata[W-1] ^ s_tdata[32+W-1];
	assign in_bn_s = s_tdata[64+W-1] ^ s_tdata[96+W-1];

	assign is_cmp = (kind_q != KIND_ADD) && (kind_q != KIND_SUB)
		&& (kind_q != KIND_MUL) && (kind_q != KIND_DIV);

	always_comb begin
		mx = ad_q;
		my = bd_q;
		ms = 1'b0;
		case (kind_q)
			KIND_MUL: begin
				if (mi_q == 2'd0) begin
					mx = an_q; my = bn_q; ms = an_s_q ^ bn_s_q;
				end
			end
			KIND_DIV: begin
				if (mi_q == 2'd0) begin
					mx = an_q; my = bd_q; ms = an_s_q;
				end else begin
					mx = ad_q; my = bn_q; ms = bn_s_q;
				end
			end
			default: begin
				if (mi_q == 2'd0) begin
					mx = an_q; my = bd_q; ms = an_s_q;
				end else if (mi_q == 2'd1) begin
					mx = bn_q; my = ad_q; ms = bn_s_q;
				end
			end
		endcase
	end

	assign prod = P'(mx) * P'(my);

	// signed-magnitude sum of the two cross products
	assign s1_eff = (kind_q == KIND_ADD) ? s1_q : (s1_q ^ (p1_q != '0));
	always_comb begin
		if (s0_q == s1_eff) begin
			sum_m = p0_q + p1_q;
			sum_s = s0_q;
		end else if (p0_q >= p1_q) begin
			sum_m = p0_q - p1_q;
			sum_s = s0_q;
		end else begin
			sum_m = p1_q - p0_q;
			sum_s = s1_eff;
		end
		if (sum_m == '0)
			sum_s = 1'b0;
	end

	always_comb begin
		nm_c = sum_m;
		nn_c = sum_s;
		dm_c = p2_q;
		dn_c = 1'b0;
		case (kind_q)
			KIND_MUL: begin
				nm_c = p0_q; nn_c = s0_q; dm_c = p1_q;
			end
			KIND_DIV: begin
				nm_c = p0_q; nn_c = s0_q; dm_c = p1_q; dn_c = s1_q;
			end
			default: ;
		endcase
	end

	// shared subtract/compare for the division steps
	assign r2 = {rem_q, dv_q[P-1]};
	assign ge = r2 >= {1'b0, g_q};
	assign r2_sub = P'(r2 - {1'b0, g_q});

	always_comb begin
		nm_sat = nq_q;
		ov_c = 1'b0;
		if (neg_q) begin
			if (nq_q > LIM) begin
				nm_sat = LIM; ov_c = 1'b1;
			end
		end else if (nq_q > LIM - 1'b1) begin
			nm_sat = LIM - 1'b1; ov_c = 1'b1;
		end
		dm_sat = {dv_q[P-2:0], ge};
		if (dm_sat > LIM - 1'b1) begin
			dm_sat = LIM - 1'b1; ov_c = 1'b1;
		end
		resn = neg_q ? (~nm_sat + 1'b1) : nm_sat;
	end

	assign out_free = !m_tvalid || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (in_ad == '0 || in_bd == '0)
							state_q <= ST_FIN;
						else
							state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mi_q == 2'd2)
						state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (is_cmp || dm_c == '0)
						state_q <= ST_FIN;
					else
						state_q <= ST_GCD;
				end
				ST_GCD: begin
					if (u_q == '0)
						state_q <= ST_DIVN;
				end
				ST_DIVN: begin
					if (cnt_q == CNT_BITS'(P - 1))
						state_q <= ST_DIVD;
				end
				ST_DIVD: begin
					if (cnt_q == CNT_BITS'(P - 1))
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				kind_q <= s_tuser;
				an_q <= in_an;
				ad_q <= in_ad;
				bn_q <= in_bn;
				bd_q <= in_bd;
				an_s_q <= in_an_s;
				bn_s_q <= in_bn_s;
				mi_q <= 2'd0;
				rn_q <= '0;
				rd_q <= '0;
				ord_q <= ORD_LESS;
				zde_q <= 1'b1;
				ov_q <= 1'b0;
			end
			ST_MUL: begin
				mi_q <= mi_q + 2'd1;
				if (mi_q == 2'd0) begin
					p0_q <= prod; s0_q <= ms && (prod != '0);
				end else if (mi_q == 2'd1) begin
					p1_q <= prod; s1_q <= ms && (prod != '0);
				end else begin
					p2_q <= prod;
				end
			end
			ST_ADD: begin
				if (is_cmp) begin
					zde_q <= 1'b0;
					rd_q <= 31'd1;
					ord_q <= (sum_m == '0) ? ORD_EQUAL : (sum_s ? ORD_LESS : ORD_MORE);
				end else if (dm_c != '0) begin
					zde_q <= 1'b0;
				end
				n_q <= nm_c;
				d_q <= dm_c;
				u_q <= nm_c;
				v_q <= dm_c;
				k_q <= '0;
				neg_q <= (nm_c != '0) && (nn_c != dn_c);
			end
			ST_GCD: begin
				if (u_q == '0) begin
					g_q <= v_q << k_q;
					dv_q <= n_q;
					rem_q <= '0;
					cnt_q <= '0;
				end else if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (u_q >= v_q) begin
					u_q <= u_q - v_q;
				end else begin
					v_q <= v_q - u_q;
				end
			end
			ST_DIVN: begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_BITS'(P - 1)) begin
					nq_q <= {dv_q[P-2:0], ge};
					dv_q <= d_q;
					rem_q <= '0;
				end else begin
					dv_q <= {dv_q[P-2:0], ge};
					rem_q <= ge ? r2_sub : r2[P-1:0];
				end
			end
			ST_DIVD: begin
				cnt_q <= cnt_q + 1'b1;
				dv_q <= {dv_q[P-2:0], ge};
				rem_q <= ge ? r2_sub : r2[P-1:0];
				if (cnt_q == CNT_BITS'(P - 1)) begin
					rn_q <= 32'(signed'(resn[W-1:0]));
					rd_q <= 31'(dm_sat[W-2:0]);
					ov_q <= ov_c;
				end
			end
			ST_FIN: begin
				if (out_free)
					m_tdata <= {5'd0, ov_q, zde_q, ord_q, rd_q, rn_q};
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[65] |-> m_tdata[62:0] == '0 && !m_tdata[66])
		else $error("error result carries data");
	a_den_nz: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[65] |-> m_tdata[62:32] != '0)
		else $error("zero denominator without error");
	a_gcd_v: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_GCD |-> v_q != '0)
		else $error("gcd operand lost");
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && out_free |=> m_tvalid && state_q == ST_IDLE)
		else $error("result not issued");
`endif

endmodule
